/* sv/rcbp_pkg.sv */
// Shared types and constants for the reference-counted buffer pool.
// Used by refcounted_buffer_pool; depends on nothing else.
package rcbp_pkg;

   // Default sizing handed to the top-level parameters
   localparam int POOL_MAX_DEFAULT   = 64;
   localparam int COUNT_BITS_DEFAULT = 8;

   // Field widths of the transaction payloads
   localparam int CMD_W    = 2;
   localparam int BUF_W    = 6;
   localparam int STATUS_W = 3;
   localparam int REFCNT_W = 8;
   localparam int FREECNT_W = 7;
   localparam int CSR_W    = 7;

   localparam logic [CSR_W-1:0] POOL_SIZE_RESET = 7'd64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ADD_REF = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FREE_BUF  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [BUF_W-1:0] buffer;
   } req_type;

   typedef struct packed {
      logic [BUF_W-1:0]     granted;
      logic [STATUS_W-1:0]  status;
      logic                 freed;
      logic [REFCNT_W-1:0]  ref_count;
      logic [FREECNT_W-1:0] free_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

/* sv/rcbp_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Standalone; instantiated by refcounted_buffer_pool for the stack and the counts.
module rcbp_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered: data in the cycle after an enabled read; hold otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/refcounted_buffer_pool.sv */
// Reference-counted buffer pool: LIFO free stack plus one count per buffer.
// Acquire, release and add reference: memory read on accept, then modify
// and write back in EXEC; req_stall holds until then, result registered.
// Init sweeps pool_size entries of both memories, one a cycle, then answers.
// Synchronous reset runs the same sweep over POOL_MAX entries with req_stall
// high; csr writes are taken throughout. Depends on rcbp_pkg and rcbp_ram.
module refcounted_buffer_pool #(
   parameter int POOL_MAX   = rcbp_pkg::POOL_MAX_DEFAULT,
   parameter int COUNT_BITS = rcbp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rcbp_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rcbp_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rcbp_pkg::CSR_W-1:0]    csr_data
);

   localparam int IDX_W = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
   localparam int TOP_W = $clog2(POOL_MAX + 1);

   rcbp_pkg::state_type state_ff, state_in;
   logic [rcbp_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [rcbp_pkg::BUF_W-1:0] buf_ff, buf_in;
   logic [TOP_W-1:0]           top_ff, top_in;
   logic [TOP_W-1:0]           active_n_ff, active_n_in;
   logic [TOP_W-1:0]           sweep_ff, sweep_in;
   logic                       sweep_rsp_ff, sweep_rsp_in;
   logic [rcbp_pkg::CSR_W-1:0] pool_size_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   rcbp_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic                       rsp_load;

   logic                  req_accept;
   logic                  rsp_free;
   logic [TOP_W-1:0]      n_clamped;
   logic                  bad_index;

   logic                  stk_wr_en, cnt_wr_en;
   logic [IDX_W-1:0]      stk_wr_addr, cnt_wr_addr;
   logic [IDX_W-1:0]      stk_wr_data;
   logic [COUNT_BITS-1:0] cnt_wr_data;
   logic [IDX_W-1:0]      stk_rd_addr, cnt_rd_addr;
   logic [IDX_W-1:0]      stk_rd_data;
   logic [COUNT_BITS-1:0] cnt_rd_data;

   assign req_stall  = (state_ff != rcbp_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Clamp the programmed pool size to 1 .. POOL_MAX
   always_comb begin
      if (pool_size_ff == '0) begin
         n_clamped = TOP_W'(1);
      end else if (32'(pool_size_ff) > POOL_MAX) begin
         n_clamped = TOP_W'(POOL_MAX);
      end else begin
         n_clamped = TOP_W'(pool_size_ff);
      end
   end

   assign bad_index = (32'(buf_ff) >= 32'(active_n_ff));

   // Read addresses: stack top entry, and the count of the request's buffer (of buffer active_n-1 for acquire)
   assign stk_rd_addr = IDX_W'(top_ff - TOP_W'(1));
   assign cnt_rd_addr = (req_data.cmd == rcbp_pkg::CMD_ACQUIRE) ?
                        IDX_W'(active_n_ff - TOP_W'(1)) : IDX_W'(req_data.buffer);

   rcbp_ram #(
      .DEPTH  (POOL_MAX),
      .WIDTH  (IDX_W),
      .ADDR_W (IDX_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (req_accept),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   rcbp_ram #(
      .DEPTH  (POOL_MAX),
      .WIDTH  (COUNT_BITS),
      .ADDR_W (IDX_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (req_accept),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // Next state, memory write-back and result
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      buf_in       = buf_ff;
      top_in       = top_ff;
      active_n_in  = active_n_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = sweep_ff[IDX_W-1:0];
      stk_wr_data  = sweep_ff[IDX_W-1:0];
      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = sweep_ff[IDX_W-1:0];
      cnt_wr_data  = '0;
      rsp_load     = 1'b0;
      rsp_data_in  = '0;

      unique case (state_ff)
         rcbp_pkg::ST_SWEEP: begin
            // Refill one stack entry and clear one count per cycle
            stk_wr_en = 1'b1;
            cnt_wr_en = 1'b1;
            sweep_in  = sweep_ff + TOP_W'(1);
            if (sweep_ff == active_n_ff - TOP_W'(1)) begin
               state_in = sweep_rsp_ff ? rcbp_pkg::ST_EXEC : rcbp_pkg::ST_IDLE;
            end
         end

         rcbp_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in = req_data.cmd;
               buf_in = req_data.buffer;
               if (req_data.cmd == rcbp_pkg::CMD_INIT) begin
                  active_n_in  = n_clamped;
                  top_in       = n_clamped;
                  sweep_in     = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = rcbp_pkg::ST_SWEEP;
               end else begin
                  state_in = rcbp_pkg::ST_EXEC;
               end
            end
         end

         rcbp_pkg::ST_EXEC: begin
            // Commit only when the result register can take the transaction
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = rcbp_pkg::ST_IDLE;
               rsp_data_in.granted = buf_ff;
               rsp_data_in.status  = rcbp_pkg::STATUS_OK;
               unique case (cmd_ff) inside
                  rcbp_pkg::CMD_INIT: begin
                     rsp_data_in.granted = '0;
                     sweep_rsp_in        = 1'b0;
                  end
                  rcbp_pkg::CMD_ACQUIRE: begin
                     if (top_ff == '0) begin
                        rsp_data_in.granted   = rcbp_pkg::BUF_W'(active_n_ff - TOP_W'(1));
                        rsp_data_in.status    = rcbp_pkg::STATUS_EXHAUSTED;
                        rsp_data_in.ref_count = rcbp_pkg::REFCNT_W'(cnt_rd_data);
                     end else begin
                        // Pop and mark the buffer as held once
                        top_in                = top_ff - TOP_W'(1);
                        cnt_wr_en             = 1'b1;
                        cnt_wr_addr           = stk_rd_data;
                        cnt_wr_data           = COUNT_BITS'(1);
                        rsp_data_in.granted   = rcbp_pkg::BUF_W'(stk_rd_data);
                        rsp_data_in.ref_count = rcbp_pkg::REFCNT_W'(1);
                     end
                  end
                  rcbp_pkg::CMD_RELEASE, rcbp_pkg::CMD_ADD_REF: begin
                     if (bad_index) begin
                        rsp_data_in.status = rcbp_pkg::STATUS_BAD_INDEX;
                     end else if (cnt_rd_data == '0) begin
                        rsp_data_in.status = rcbp_pkg::STATUS_FREE_BUF;
                     end else if (cmd_ff == rcbp_pkg::CMD_RELEASE) begin
                        // Drop one reference; push back on the last one
                        cnt_wr_en             = 1'b1;
                        cnt_wr_addr           = IDX_W'(buf_ff);
                        cnt_wr_data           = cnt_rd_data - COUNT_BITS'(1);
                        rsp_data_in.ref_count = rcbp_pkg::REFCNT_W'(cnt_wr_data);
                        if (cnt_rd_data == COUNT_BITS'(1) && 32'(top_ff) < POOL_MAX) begin
                           stk_wr_en         = 1'b1;
                           stk_wr_addr       = top_ff[IDX_W-1:0];
                           stk_wr_data       = IDX_W'(buf_ff);
                           top_in            = top_ff + TOP_W'(1);
                           rsp_data_in.freed = 1'b1;
                        end
                     end else if (&cnt_rd_data) begin
                        rsp_data_in.status    = rcbp_pkg::STATUS_SATURATED;
                        rsp_data_in.ref_count = rcbp_pkg::REFCNT_W'(cnt_rd_data);
                     end else begin
                        cnt_wr_en             = 1'b1;
                        cnt_wr_addr           = IDX_W'(buf_ff);
                        cnt_wr_data           = cnt_rd_data + COUNT_BITS'(1);
                        rsp_data_in.ref_count = rcbp_pkg::REFCNT_W'(cnt_wr_data);
                     end
                  end
                  default: begin
                     rsp_data_in.status = rcbp_pkg::STATUS_OK;
                  end
               endcase
               rsp_data_in.free_count = rcbp_pkg::FREECNT_W'(top_in);
            end
         end

         default: begin
            state_in = rcbp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcbp_pkg::ST_SWEEP;
         top_ff       <= TOP_W'(POOL_MAX);
         active_n_ff  <= TOP_W'(POOL_MAX);
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         active_n_ff  <= active_n_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pool size register
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= rcbp_pkg::POOL_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         pool_size_ff <= csr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      buf_ff <= buf_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
